@@ rtl/core/bitap_pkg.sv @@
`default_nettype none

package bitap_pkg;

    // Pattern word width and the deepest error level that storage holds.
    localparam int unsigned VEC_W      = 64;
    localparam int unsigned MAX_ERRORS = 8;
    localparam int unsigned LEVELS     = MAX_ERRORS + 1;
    localparam int unsigned LVL_W      = 4;
    localparam int unsigned PLEN_W     = 7;
    localparam int unsigned TOP_W      = 6;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef logic [VEC_W-1:0]  t_vec;
    typedef logic [LVL_W-1:0]  t_level;

    localparam t_vec   VEC_ONES  = '1;
    localparam t_level LEVEL_MAX = t_level'(MAX_ERRORS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_A   = 3'd0,
        CFG_MASK_C   = 3'd1,
        CFG_MASK_G   = 3'd2,
        CFG_MASK_T   = 3'd3,
        CFG_PLEN     = 3'd4,
        CFG_MAX_ERR  = 3'd5
    } t_cfg_idx;

    // Base codes.
    typedef enum logic [1:0] {
        BASE_A = 2'd0,
        BASE_C = 2'd1,
        BASE_G = 2'd2,
        BASE_T = 2'd3
    } t_base;

    // Operands of one level update.
    typedef struct packed {
        logic level0;
        t_vec bm;
        t_vec old_same;
        t_vec prev_old;
        t_vec prev_new;
    } t_lvl_in;

    // Vectors produced by one level update.
    typedef struct packed {
        t_vec match_bits;
        t_vec subst_bits;
        t_vec insert_bits;
        t_vec del_bits;
        t_vec new_vec;
    } t_lvl_out;

endpackage

`default_nettype wire

@@ rtl/core/bitap_ram.sv @@
`default_nettype none

module bitap_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/bitap_level.sv @@
`default_nettype none

module bitap_level (
    input  wire bitap_pkg::t_lvl_in  i_op,
    output bitap_pkg::t_lvl_out      o_res
);
    import bitap_pkg::*;

    t_vec match_v;

    // Level zero has no lower level: its edit vectors are all ones and the
    // new vector is the match vector alone.
    always_comb begin
        match_v = (i_op.old_same << 1) | i_op.bm;
        o_res.match_bits = match_v;
        if (i_op.level0) begin
            o_res.subst_bits  = VEC_ONES;
            o_res.insert_bits = VEC_ONES;
            o_res.del_bits    = VEC_ONES;
            o_res.new_vec     = match_v;
        end else begin
            o_res.subst_bits  = i_op.prev_old << 1;
            o_res.insert_bits = i_op.prev_new << 1;
            o_res.del_bits    = i_op.prev_old;
            o_res.new_vec     = match_v & (i_op.prev_old << 1)
                              & (i_op.prev_new << 1) & i_op.prev_old;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bitap_dna_edit_distance_bitvectors_unit.sv @@
`default_nettype none
// Bitap approximate matcher for one DNA pattern of up to 64 bases.
// Input channel (i_in_valid / o_in_ready) carries one text character per
// transfer, last text base first: a 2-bit base code, an is-base flag and a
// restart flag that sets every error-level vector to all ones first.
// Output channel (o_out_valid / i_out_ready) carries one result per error
// level 0..k, k = min(max_errors, 8), in rising level order; the result for
// level k has last_level set and reports found and best_error.
// The user must write the configuration port (i_cfg_we, i_cfg_idx,
// i_cfg_data) only while the block is idle; the block does not enforce it.
// Each write takes effect at the same clock edge. The level vectors sit in
// a 9-entry RAM with a registered read. One level is read, updated and
// written back per cycle unless the receiver stalls; a base holds off the
// next transfer until its last level is written back. A character that is
// not a base leaves the block idle and produces no result. Reset
// (synchronous, active low) restores the configuration defaults and marks
// every RAM entry as invalid, which reads as all ones; the restart flag
// does the same to the entries. When the receiver stalls, the output
// register holds its result and the level sequencer waits with it.
module bitap_dna_edit_distance_bitvectors_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bitap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bitap_pkg::VEC_W-1:0]  i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_in_base,
    input  wire logic                         i_in_is_base,
    input  wire logic                         i_in_new_text,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [bitap_pkg::LVL_W-1:0]       o_out_error_level,
    output logic [bitap_pkg::VEC_W-1:0]       o_out_match_bits,
    output logic [bitap_pkg::VEC_W-1:0]       o_out_subst_bits,
    output logic [bitap_pkg::VEC_W-1:0]       o_out_insert_bits,
    output logic [bitap_pkg::VEC_W-1:0]       o_out_delete_bits,
    output logic                              o_out_last_level,
    output logic                              o_out_found,
    output logic [bitap_pkg::LVL_W-1:0]       o_out_best_error
);
    import bitap_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    // Configuration registers.
    t_vec                r_mask_a, r_mask_c, r_mask_g, r_mask_t;
    logic [PLEN_W-1:0]   r_plen;
    logic [LVL_W-1:0]    r_max_err;

    // Sequencer state.
    t_state              r_state, n_state;
    t_level              r_lvl;
    logic [LEVELS-1:0]   r_valid;
    t_vec                r_bm;
    t_vec                r_prev_old;
    t_vec                r_prev_new;
    logic                r_found;
    t_level              r_best;

    // Output register.
    logic                r_out_valid;

    logic                in_xfer;
    logic                advance;
    logic                is_last;
    t_level              k_lvl;
    logic [TOP_W-1:0]    top_idx;
    t_vec                sel_mask;
    t_level              raddr;
    t_vec                rdata;
    t_lvl_in             lvl_op;
    t_lvl_out            lvl_res;
    logic                hit;
    logic                found_now;
    t_level              best_now;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign advance     = (r_state == S_CALC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // A threshold above the deepest stored level acts as the deepest level.
    assign k_lvl   = (r_max_err > LEVEL_MAX) ? LEVEL_MAX : r_max_err;
    assign is_last = (r_lvl == k_lvl);

    // Found bit position: length zero acts as one, anything past the word
    // acts as the full word.
    always_comb begin
        if (r_plen == '0) begin
            top_idx = '0;
        end else if (r_plen > PLEN_W'(VEC_W)) begin
            top_idx = TOP_W'(VEC_W - 1);
        end else begin
            top_idx = TOP_W'(r_plen - PLEN_W'(1));
        end
    end

    always_comb begin
        case (t_base'(i_in_base))
            BASE_A:  sel_mask = r_mask_a;
            BASE_C:  sel_mask = r_mask_c;
            BASE_G:  sel_mask = r_mask_g;
            default: sel_mask = r_mask_t;
        endcase
    end

    // While idle the RAM keeps level zero on its read port so the first
    // level of a new base finds its old vector ready. While computing, the
    // next level is fetched as the current one is written back; a stall
    // keeps the current address so the read data stays put.
    always_comb begin
        if (r_state == S_CALC && !advance) begin
            raddr = r_lvl;
        end else if (r_state == S_CALC && !is_last) begin
            raddr = r_lvl + t_level'(1);
        end else begin
            raddr = '0;
        end
    end

    bitap_ram #(
        .WIDTH (VEC_W),
        .DEPTH (LEVELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_lvl),
        .i_wdata (lvl_res.new_vec),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // An entry not written since reset or the last restart reads as ones.
    always_comb begin
        lvl_op.level0   = (r_lvl == '0);
        lvl_op.bm       = r_bm;
        lvl_op.old_same = r_valid[r_lvl] ? rdata : VEC_ONES;
        lvl_op.prev_old = r_prev_old;
        lvl_op.prev_new = r_prev_new;
    end

    bitap_level u_level (
        .i_op  (lvl_op),
        .o_res (lvl_res)
    );

    // The lowest level whose found bit is clear wins.
    assign hit       = !lvl_res.new_vec[top_idx];
    assign found_now = r_found || hit;
    assign best_now  = r_found ? r_best : (hit ? r_lvl : '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_in_is_base) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (advance && is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a  <= VEC_ONES;
            r_mask_c  <= VEC_ONES;
            r_mask_g  <= VEC_ONES;
            r_mask_t  <= VEC_ONES;
            r_plen    <= PLEN_W'(VEC_W);
            r_max_err <= LEVEL_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASK_A:  r_mask_a  <= i_cfg_data;
                CFG_MASK_C:  r_mask_c  <= i_cfg_data;
                CFG_MASK_G:  r_mask_g  <= i_cfg_data;
                CFG_MASK_T:  r_mask_t  <= i_cfg_data;
                CFG_PLEN:    r_plen    <= i_cfg_data[PLEN_W-1:0];
                CFG_MAX_ERR: r_max_err <= i_cfg_data[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_lvl       <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                if (i_in_new_text) begin
                    r_valid <= '0;
                end
                r_lvl   <= '0;
                r_found <= 1'b0;
                r_best  <= '0;
            end else if (advance) begin
                r_valid[r_lvl] <= 1'b1;
                r_lvl          <= r_lvl + t_level'(1);
                r_found        <= found_now;
                r_best         <= best_now;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bm <= sel_mask;
        end
        if (advance) begin
            r_prev_old        <= lvl_op.old_same;
            r_prev_new        <= lvl_res.new_vec;
            o_out_error_level <= r_lvl;
            o_out_match_bits  <= lvl_res.match_bits;
            o_out_subst_bits  <= lvl_res.subst_bits;
            o_out_insert_bits <= lvl_res.insert_bits;
            o_out_delete_bits <= lvl_res.del_bits;
            o_out_last_level  <= is_last;
            o_out_found       <= is_last && found_now;
            o_out_best_error  <= is_last ? best_now : '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bitap_chk.sv @@
`default_nettype none

module bitap_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [bitap_pkg::LVL_W-1:0]  o_out_error_level,
    input wire logic [bitap_pkg::VEC_W-1:0]  o_out_match_bits,
    input wire logic [bitap_pkg::VEC_W-1:0]  o_out_subst_bits,
    input wire logic [bitap_pkg::VEC_W-1:0]  o_out_insert_bits,
    input wire logic [bitap_pkg::VEC_W-1:0]  o_out_delete_bits,
    input wire logic                         o_out_last_level,
    input wire logic                         o_out_found,
    input wire logic [bitap_pkg::LVL_W-1:0]  o_out_best_error
);
    import bitap_pkg::*;

    // A stalled result stays on the port.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_error_level) && $stable(o_out_match_bits))
        else $error("stalled result changed");

    // Level zero results carry all-ones edit vectors.
    a_level0_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_error_level == '0) |->
            (o_out_subst_bits == VEC_ONES) && (o_out_insert_bits == VEC_ONES)
            && (o_out_delete_bits == VEC_ONES))
        else $error("level zero edit vectors not all ones");

    // Only the last result of a base reports a match.
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last_level |->
            !o_out_found && (o_out_best_error == '0))
        else $error("match report on a result that is not the last");

    // Best level <= level of the last result <= LEVEL_MAX.
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last_level |->
            (o_out_best_error <= o_out_error_level) && (o_out_error_level <= LEVEL_MAX))
        else $error("best level out of range");

    // A result of a level above zero follows its lower level.
    a_level_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_last_level |=>
            !o_out_valid || (o_out_error_level == $past(o_out_error_level) + 4'd1))
        else $error("level results out of order");

endmodule

bind bitap_dna_edit_distance_bitvectors_unit bitap_chk u_chk (.*);

`default_nettype wire
